FILE: rtl/core/rpf_pkg.sv
// Shared types and constants for the range prime finder.
package rpf_pkg;

  localparam int DEF_MAX_SPAN  = 64;
  localparam int DEF_NUM_WIDTH = 32;
  localparam int FIELD_W       = 32;

  typedef enum logic [1:0] {
    ST_PRIME   = 2'd0,
    ST_NONE    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_CAND,
    S_TEST,
    S_DIV,
    S_REM,
    S_FOUND,
    S_ADV,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic load;       // take a new request
    logic check;      // latch the range check
    logic cand_init;  // first odd divisor 3, square 9
    logic div_start;  // start remainder unit
    logic div_step;   // one remainder bit
    logic next_div;   // next odd divisor
    logic found;      // current number is prime
    logic adv;        // next number
    logic final_res;  // closing result of the request
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic n_lt2;
    logic n_is2;
    logic n_even;
    logic sq_gt_n;
    logic div_done;
    logic rem_zero;
    logic n_eq_hi;
    logic slot_free;
    logic pend_valid;
  } stat_t;

endpackage

FILE: rtl/core/rpf_ctrl.sv
// Controller state machine for the range prime finder.
module rpf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rpf_pkg::stat_t stat,
  output rpf_pkg::cmd_t  cmd
);

  rpf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      rpf_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = rpf_pkg::S_CHECK;
        end
      end
      rpf_pkg::S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.bad) begin
          state_next = rpf_pkg::S_FINAL;
        end else begin
          state_next = rpf_pkg::S_CAND;
        end
      end
      rpf_pkg::S_CAND: begin
        priority if (stat.n_lt2) begin
          state_next = rpf_pkg::S_ADV;
        end else if (stat.n_is2) begin
          state_next = rpf_pkg::S_FOUND;
        end else if (stat.n_even) begin
          state_next = rpf_pkg::S_ADV;
        end else begin
          cmd.cand_init = 1'b1;
          state_next    = rpf_pkg::S_TEST;
        end
      end
      rpf_pkg::S_TEST: begin
        if (stat.sq_gt_n) begin
          state_next = rpf_pkg::S_FOUND;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = rpf_pkg::S_DIV;
        end
      end
      rpf_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = rpf_pkg::S_REM;
        end
      end
      rpf_pkg::S_REM: begin
        if (stat.rem_zero) begin
          state_next = rpf_pkg::S_ADV;
        end else begin
          cmd.next_div = 1'b1;
          state_next   = rpf_pkg::S_TEST;
        end
      end
      rpf_pkg::S_FOUND: begin
        if (stat.slot_free || !stat.pend_valid) begin
          cmd.found  = 1'b1;
          state_next = rpf_pkg::S_ADV;
        end
      end
      rpf_pkg::S_ADV: begin
        if (stat.n_eq_hi) begin
          state_next = rpf_pkg::S_FINAL;
        end else begin
          cmd.adv    = 1'b1;
          state_next = rpf_pkg::S_CAND;
        end
      end
      rpf_pkg::S_FINAL: begin
        if (stat.slot_free) begin
          cmd.final_res = 1'b1;
          state_next    = rpf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rpf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/rpf_datapath.sv
// Datapath: range registers, odd divisor and square, bit-serial remainder, result register.
module rpf_datapath #(
  parameter int NUM_WIDTH = rpf_pkg::DEF_NUM_WIDTH,
  parameter int MAX_SPAN  = rpf_pkg::DEF_MAX_SPAN
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rpf_pkg::FIELD_W-1:0] range_low,
  input  logic [rpf_pkg::FIELD_W-1:0] range_high,
  input  rpf_pkg::cmd_t               cmd,
  output rpf_pkg::stat_t              stat,
  output logic [rpf_pkg::FIELD_W-1:0] prime_value,
  output logic [1:0]                  status,
  output logic                        last,
  output logic                        res_valid,
  input  logic                        res_ready
);

  localparam int IW = (NUM_WIDTH < rpf_pkg::FIELD_W) ? NUM_WIDTH : rpf_pkg::FIELD_W;
  localparam int CW = $clog2(NUM_WIDTH + 1);

  logic [NUM_WIDTH-1:0]   n;
  logic [NUM_WIDTH-1:0]   hi;
  logic [NUM_WIDTH-1:0]   d;
  logic [NUM_WIDTH+1:0]   sq;
  logic [NUM_WIDTH:0]     rem;
  logic [NUM_WIDTH-1:0]   quo;
  logic [CW-1:0]          cnt;
  logic [NUM_WIDTH-1:0]   pend;
  logic                   pend_valid;
  logic                   bad;
  logic                   bad_now;
  logic [NUM_WIDTH:0]     rem_sh;
  logic                   emit_pend;
  logic [NUM_WIDTH-1:0]   out_value;
  rpf_pkg::status_t       out_status;
  logic                   out_last;

  assign bad_now = (n == '0) || (hi == '0) || (n >= hi) ||
                   ((hi - n) > NUM_WIDTH'(MAX_SPAN));
  assign rem_sh  = {rem[NUM_WIDTH-1:0], quo[NUM_WIDTH-1]};
  assign emit_pend = cmd.found && pend_valid;

  assign stat.bad        = bad_now;
  assign stat.n_lt2      = (n < NUM_WIDTH'(2));
  assign stat.n_is2      = (n == NUM_WIDTH'(2));
  assign stat.n_even     = ~n[0];
  assign stat.sq_gt_n    = (sq > {2'b00, n});
  assign stat.div_done   = (cnt == CW'(1));
  assign stat.rem_zero   = (rem == '0);
  assign stat.n_eq_hi    = (n == hi);
  assign stat.slot_free  = ~res_valid | res_ready;
  assign stat.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n  <= NUM_WIDTH'(range_low[IW-1:0]);
      hi <= NUM_WIDTH'(range_high[IW-1:0]);
    end else if (cmd.adv) begin
      n <= n + NUM_WIDTH'(1);
    end
    if (cmd.check) begin
      bad <= bad_now;
    end
    if (cmd.cand_init) begin
      d  <= NUM_WIDTH'(3);
      sq <= (NUM_WIDTH + 2)'(9);
    end else if (cmd.next_div) begin
      d  <= d + NUM_WIDTH'(2);
      sq <= sq + {d, 2'b00} + (NUM_WIDTH + 2)'(4);
    end
    if (cmd.div_start) begin
      rem <= '0;
      quo <= n;
      cnt <= CW'(NUM_WIDTH);
    end else if (cmd.div_step) begin
      quo <= {quo[NUM_WIDTH-2:0], 1'b0};
      cnt <= cnt - CW'(1);
      if (rem_sh >= {1'b0, d}) begin
        rem <= rem_sh - {1'b0, d};
      end else begin
        rem <= rem_sh;
      end
    end
    if (cmd.found) begin
      pend <= n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.load) begin
      pend_valid <= 1'b0;
    end else if (cmd.found) begin
      pend_valid <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_pend || cmd.final_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_pend) begin
      out_value  <= pend;
      out_status <= rpf_pkg::ST_PRIME;
      out_last   <= 1'b0;
    end else if (cmd.final_res) begin
      priority if (bad) begin
        out_value  <= '0;
        out_status <= rpf_pkg::ST_INVALID;
      end else if (pend_valid) begin
        out_value  <= pend;
        out_status <= rpf_pkg::ST_PRIME;
      end else begin
        out_value  <= '0;
        out_status <= rpf_pkg::ST_NONE;
      end
      out_last <= 1'b1;
    end
  end

  assign prime_value = rpf_pkg::FIELD_W'(out_value);
  assign status      = out_status;
  assign last        = out_last;

endmodule

FILE: rtl/core/range_prime_finder.sv
// Top level of the range prime finder: controller plus datapath.
//
// Request channel (req_valid/req_ready, range_low, range_high): one transfer
// is a range to search. It is taken only while no earlier request is open.
// Result channel (res_valid/res_ready, prime_value, status, last): one
// transfer per prime in ascending order, or a single no-primes or invalid
// result; last marks the closing transfer of a request.
// Flow: a request is loaded into the range registers, its range check is
// latched in the check state, and an invalid range goes straight to the final
// state. Each odd candidate n tries up to about (sqrt(n)/2) odd trial divisors,
// each on the one-bit-per-cycle remainder unit. A prime is held back until the
// next prime or the range end, so last can be marked.
// Throughput: one request at a time; the next request is taken the cycle
// after the closing result is loaded into the output register.
// Reset clears the state machine and the output valid; no results survive.
// On a receiver stall the output register holds its result; the search waits
// until it frees at a prime that must push out a held prime or at the range end.
module range_prime_finder #(
  parameter int NUM_WIDTH = rpf_pkg::DEF_NUM_WIDTH,
  parameter int MAX_SPAN  = rpf_pkg::DEF_MAX_SPAN
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [rpf_pkg::FIELD_W-1:0] range_low,
  input  logic [rpf_pkg::FIELD_W-1:0] range_high,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [rpf_pkg::FIELD_W-1:0] prime_value,
  output logic [1:0]                  status,
  output logic                        last
);

  rpf_pkg::cmd_t  cmd;
  rpf_pkg::stat_t stat;

  rpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rpf_datapath #(
    .NUM_WIDTH (NUM_WIDTH),
    .MAX_SPAN  (MAX_SPAN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .range_low   (range_low),
    .range_high  (range_high),
    .cmd         (cmd),
    .stat        (stat),
    .prime_value (prime_value),
    .status      (status),
    .last        (last),
    .res_valid   (res_valid),
    .res_ready   (res_ready)
  );

`ifndef SYNTH
  a_prime_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == rpf_pkg::ST_PRIME) |-> (prime_value >= 2))
    else $error("prime result below two");

  a_other_closes: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status != rpf_pkg::ST_PRIME) |-> last && (prime_value == '0))
    else $error("non-prime result not closing or nonzero");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.final_res || (cmd.found && stat.pend_valid)) |-> stat.slot_free)
    else $error("result loaded over an untaken result");
`endif

endmodule
